// ----- sv/complex_arithmetic_unit_assert.svh -----
// assertion macros used by the complex arithmetic unit checker
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
// same-cycle implication, sampled on clk, off while rst is high
`define CAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("complex_arithmetic_unit check failed");
// next-cycle implication, sampled on clk, off while rst is high
`define CAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("complex_arithmetic_unit check failed");
`endif

// ----- sv/cau_pkg.sv -----
// types, constants and helper functions of the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;
  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int UNIT_LAT     = 34;
  localparam int CORDIC_STEPS = 17;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;
  localparam logic [2:0] CMD_MAG = 3'd5;
  localparam logic [2:0] CMD_ANG = 3'd6;

  localparam logic signed [31:0] DEG180 = 32'sd11796480;
  localparam logic signed [31:0] DEG90  = 32'sd5898240;
  localparam logic signed [31:0] MAX32  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32  = 32'sh8000_0000;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP, OP_MAG, OP_ANG, OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } item_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               eq;
    logic               dz;
    logic               ovf;
  } res_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'(MAX32)) begin
      r.ovf = 1'b1;
      r.val = MAX32;
    end else if (v < 66'(MIN32)) begin
      r.ovf = 1'b1;
      r.val = MIN32;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // arctangent of 2^-i in Q16.16 degrees
  function automatic logic signed [31:0] atan_deg(input int unsigned idx);
    logic signed [31:0] r;
    unique case (idx)
      0:       r = 32'sd2949120;
      1:       r = 32'sd1740967;
      2:       r = 32'sd919879;
      3:       r = 32'sd466945;
      4:       r = 32'sd234379;
      5:       r = 32'sd117304;
      6:       r = 32'sd58666;
      7:       r = 32'sd29335;
      8:       r = 32'sd14668;
      9:       r = 32'sd7334;
      10:      r = 32'sd3667;
      11:      r = 32'sd1833;
      12:      r = 32'sd917;
      13:      r = 32'sd458;
      14:      r = 32'sd229;
      15:      r = 32'sd115;
      16:      r = 32'sd57;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ----- sv/cau_front.sv -----
// front end: classifies commands and queues beats for the back end
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               head_valid,
  input  logic               head_pop,
  output item_t              head
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW:0] FULL = (AW+1)'(QUEUE_DEPTH);

  item_t          entries [QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;
  op_t            op_in;
  item_t          item_in;
  logic           push, pop;

  always_comb begin
    unique case (cmd)
      CMD_ADD: op_in = OP_ADD;
      CMD_SUB: op_in = OP_SUB;
      CMD_MUL: op_in = OP_MUL;
      CMD_DIV: op_in = OP_DIV;
      CMD_CMP: op_in = OP_CMP;
      CMD_MAG: op_in = OP_MAG;
      CMD_ANG: op_in = OP_ANG;
      default: op_in = OP_NONE;
    endcase
    item_in.op   = op_in;
    item_in.a_re = a_re;
    item_in.a_im = a_im;
    item_in.b_re = b_re;
    item_in.b_im = b_im;
  end

  // no beat is taken while rst is high
  assign in_ready   = !rst && (count != FULL);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ----- sv/cau_div.sv -----
// pipelined restoring divider, one quotient bit per stage, floor and saturation
`timescale 1ns / 1ps
module cau_div import cau_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [65:0] num,
  input  logic [63:0]        den,
  output logic signed [31:0] quo,
  output logic               ovf
);
  localparam int QW = DATA_W;
  localparam int RW = 64 + QW;

  logic           neg_s [QW+1];
  logic           big_s [QW+1];
  logic [63:0]    den_s [QW+1];
  logic [RW-1:0]  rem_s [QW+1];
  logic [QW-1:0]  q_s   [QW+1];
  logic [64:0]    mag;
  logic [RW-1:0]  n_ext;
  logic [QW:0]    q_fix;

  assign mag   = num[65] ? 65'(-num) : num[64:0];
  assign n_ext = RW'({mag, {FRAC_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      neg_s[0] <= num[65];
      // quotient would need more than QW bits
      big_s[0] <= n_ext >= {den, {QW{1'b0}}};
      den_s[0] <= den;
      rem_s[0] <= n_ext;
      q_s[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    logic [RW-1:0] trial;
    assign trial = RW'(den_s[k-1]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        neg_s[k] <= neg_s[k-1];
        big_s[k] <= big_s[k-1];
        den_s[k] <= den_s[k-1];
        if (rem_s[k-1] >= trial) begin
          rem_s[k] <= rem_s[k-1] - trial;
          q_s[k]   <= q_s[k-1] | (QW'(1) << B);
        end else begin
          rem_s[k] <= rem_s[k-1];
          q_s[k]   <= q_s[k-1];
        end
      end
    end
  end

  // round toward minus infinity for negative quotients
  assign q_fix = {1'b0, q_s[QW]} + (QW+1)'(neg_s[QW] && (rem_s[QW] != '0));

  always_ff @(posedge clk) begin
    if (en) begin
      if (big_s[QW]) begin
        ovf <= 1'b1;
        quo <= neg_s[QW] ? MIN32 : MAX32;
      end else if (neg_s[QW]) begin
        if (q_fix > (QW+1)'(33'h1_0000_0000 >> 1)) begin
          ovf <= 1'b1;
          quo <= MIN32;
        end else begin
          ovf <= 1'b0;
          quo <= 32'(-q_fix);
        end
      end else if (q_fix > (QW+1)'(MAX32)) begin
        ovf <= 1'b1;
        quo <= MAX32;
      end else begin
        ovf <= 1'b0;
        quo <= q_fix[31:0];
      end
    end
  end
endmodule

// ----- sv/cau_sqrt.sv -----
// pipelined integer square root, one root bit per stage, saturating
`timescale 1ns / 1ps
module cau_sqrt import cau_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [63:0]        sq,
  output logic signed [31:0] mag,
  output logic               ovf
);
  localparam int QW = DATA_W;

  logic [65:0]   rem_s  [QW+1];
  logic [QW-1:0] root_s [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= {2'b00, sq};
      root_s[0] <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    logic [65:0] trial;
    // (root + 2^b)^2 - root^2
    assign trial = (66'(root_s[k-1]) << (B + 1)) + (66'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_s[k-1] >= trial) begin
          rem_s[k]  <= rem_s[k-1] - trial;
          root_s[k] <= root_s[k-1] | (QW'(1) << B);
        end else begin
          rem_s[k]  <= rem_s[k-1];
          root_s[k] <= root_s[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (root_s[QW][QW-1]) begin
        ovf <= 1'b1;
        mag <= MAX32;
      end else begin
        ovf <= 1'b0;
        mag <= root_s[QW];
      end
    end
  end
endmodule

// ----- sv/cau_cordic.sv -----
// pipelined cordic vectoring: angle of a complex value in Q16.16 degrees
`timescale 1ns / 1ps
module cau_cordic import cau_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  output logic signed [31:0] ang
);
  localparam int PAD = UNIT_LAT - (CORDIC_STEPS + 4);
  localparam int XW  = 35;

  typedef struct packed {
    logic rneg;
    logic ineg;
    logic rz;
    logic iz;
  } flags_t;

  flags_t             fl_a, fl_b;
  flags_t             fl_s [CORDIC_STEPS+1];
  logic [31:0]        xm_a, ym_a, mx_a, xm_b, ym_b;
  logic               rshift_b;
  logic [4:0]         shl_b;
  logic [31:0]        xn, yn;
  logic signed [XW-1:0] x_s [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_s [CORDIC_STEPS+1];
  logic signed [31:0] z_s [CORDIC_STEPS+1];
  logic signed [31:0] ang_s [PAD+1];
  logic signed [31:0] z_fin;

  function automatic logic [4:0] lead_zeros(input logic [31:0] v);
    logic [4:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  // magnitudes and special-case flags
  always_ff @(posedge clk) begin
    if (en) begin
      xm_a     <= a_re[31] ? 32'(-a_re) : a_re;
      ym_a     <= a_im[31] ? 32'(-a_im) : a_im;
      fl_a     <= '{rneg: a_re[31], ineg: a_im[31], rz: a_re == '0, iz: a_im == '0};
    end
  end

  assign mx_a = (xm_a > ym_a) ? xm_a : ym_a;

  // shift amount that puts the larger magnitude's top bit at bit 30
  always_ff @(posedge clk) begin
    if (en) begin
      xm_b     <= xm_a;
      ym_b     <= ym_a;
      fl_b     <= fl_a;
      rshift_b <= mx_a[31];
      shl_b    <= lead_zeros(mx_a) - 5'd1;
    end
  end

  assign xn = rshift_b ? (xm_b >> 1) : (xm_b << shl_b);
  assign yn = rshift_b ? (ym_b >> 1) : (ym_b << shl_b);

  always_ff @(posedge clk) begin
    if (en) begin
      fl_s[0] <= fl_b;
      x_s[0]  <= XW'({1'b0, xn});
      y_s[0]  <= (fl_b.rneg != fl_b.ineg) ? -XW'({1'b0, yn}) : XW'({1'b0, yn});
      z_s[0]  <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [XW-1:0] dx, dy;
    assign dx = y_s[i] >>> i;
    assign dy = x_s[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        fl_s[i+1] <= fl_s[i];
        if (!y_s[i][XW-1]) begin
          x_s[i+1] <= x_s[i] + dx;
          y_s[i+1] <= y_s[i] - dy;
          z_s[i+1] <= z_s[i] + atan_deg(i);
        end else begin
          x_s[i+1] <= x_s[i] - dx;
          y_s[i+1] <= y_s[i] + dy;
          z_s[i+1] <= z_s[i] - atan_deg(i);
        end
      end
    end
  end

  always_comb begin
    priority if (fl_s[CORDIC_STEPS].iz) begin
      z_fin = fl_s[CORDIC_STEPS].rneg ? DEG180 : '0;
    end else if (fl_s[CORDIC_STEPS].rz) begin
      z_fin = fl_s[CORDIC_STEPS].ineg ? -DEG90 : DEG90;
    end else if (fl_s[CORDIC_STEPS].rneg) begin
      // left half plane was folded by 180 degrees
      z_fin = z_s[CORDIC_STEPS] + (fl_s[CORDIC_STEPS].ineg ? -DEG180 : DEG180);
    end else begin
      z_fin = z_s[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_s[0] <= z_fin;
      for (int k = 1; k <= PAD; k++) begin
        ang_s[k] <= ang_s[k-1];
      end
    end
  end

  assign ang = ang_s[PAD];
endmodule

// ----- sv/complex_arithmetic_unit.sv -----
// Complex arithmetic unit on Q16.16 operands: add, sub, mul, div, compare,
// magnitude and angle of A.
//
// Input channel in_valid/in_ready carries cmd, a_re, a_im, b_re, b_im; output
// channel out_valid/out_ready carries res_re, res_im, equal, div_zero,
// overflow. Every input beat gives exactly one output beat, in order.
//
// Throughput is one beat per cycle for every command mix while the output
// is not held. A beat passes the input queue, the operand, product and sum
// registers, the back-end units and the output register, in that order.
// The back-end depth is set by the divider, which resolves one quotient bit
// per stage (the square root and cordic pipes are padded to the same depth).
//
// The four-entry input queue keeps taking beats while the back end is held,
// until it is full. When out_valid is high and out_ready low, the whole
// back-end pipeline holds and the output register keeps its beat. rst clears
// the queue and all valid bits; the block is ready as soon as rst falls.
`timescale 1ns / 1ps
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               equal,
  output logic               div_zero,
  output logic               overflow
);
  logic  en;
  logic  q_valid;
  item_t q_item;

  // stage 1: operands
  logic  v1;
  item_t it1;
  res_t  simple1;
  logic signed [32:0] add_re, add_im, sub_re, sub_im;
  sat_t  s_re, s_im;

  // stage 2: products
  logic  v2;
  op_t   op2;
  res_t  simple2;
  logic signed [31:0] ar2, ai2;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_br2, p_bi2, p_ar2, p_ai2;
  logic signed [65:0] mre_w, mim_w;
  sat_t  m_re, m_im;
  logic [63:0] den_c;
  res_t  simple2m;

  // stage 3: sums
  logic  v3;
  op_t   op3;
  res_t  simple3;
  logic  dz3;
  logic signed [31:0] ar3, ai3;
  logic signed [65:0] num_re3, num_im3;
  logic [63:0] den3, sumsq3;

  // back end
  logic  tl_v   [UNIT_LAT];
  op_t   tl_op  [UNIT_LAT];
  res_t  tl_res [UNIT_LAT];
  logic  tl_dz  [UNIT_LAT];
  logic signed [31:0] dq_re, dq_im, sq_mag, ang;
  logic  dovf_re, dovf_im, sq_ovf;
  res_t  fin, out_res;

  // whole back end advances unless a result waits on the output
  assign en = !out_valid || out_ready;

  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .a_re       (a_re),
    .a_im       (a_im),
    .b_re       (b_re),
    .b_im       (b_im),
    .head_valid (q_valid),
    .head_pop   (en),
    .head       (q_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= q_item;
    end
  end

  always_comb begin
    add_re = 33'(it1.a_re) + 33'(it1.b_re);
    add_im = 33'(it1.a_im) + 33'(it1.b_im);
    sub_re = 33'(it1.a_re) - 33'(it1.b_re);
    sub_im = 33'(it1.a_im) - 33'(it1.b_im);
    simple1 = '0;
    s_re    = '0;
    s_im    = '0;
    unique case (it1.op)
      OP_ADD: begin
        s_re = sat32(66'(add_re));
        s_im = sat32(66'(add_im));
        simple1.re  = s_re.val;
        simple1.im  = s_im.val;
        simple1.ovf = s_re.ovf | s_im.ovf;
      end
      OP_SUB: begin
        s_re = sat32(66'(sub_re));
        s_im = sat32(66'(sub_im));
        simple1.re  = s_re.val;
        simple1.im  = s_im.val;
        simple1.ovf = s_re.ovf | s_im.ovf;
      end
      OP_CMP: begin
        simple1.eq = (it1.a_re == it1.b_re) && (it1.a_im == it1.b_im);
      end
      default: begin
        simple1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2     <= it1.op;
      simple2 <= simple1;
      ar2     <= it1.a_re;
      ai2     <= it1.a_im;
      p_rr    <= it1.a_re * it1.b_re;
      p_ii    <= it1.a_im * it1.b_im;
      p_ri    <= it1.a_re * it1.b_im;
      p_ir    <= it1.a_im * it1.b_re;
      p_br2   <= it1.b_re * it1.b_re;
      p_bi2   <= it1.b_im * it1.b_im;
      p_ar2   <= it1.a_re * it1.a_re;
      p_ai2   <= it1.a_im * it1.a_im;
    end
  end

  always_comb begin
    // product rescale: arithmetic shift floors toward minus infinity
    mre_w = (66'(p_rr) - 66'(p_ii)) >>> FRAC_W;
    mim_w = (66'(p_ri) + 66'(p_ir)) >>> FRAC_W;
    m_re  = sat32(mre_w);
    m_im  = sat32(mim_w);
    den_c = 64'(p_br2) + 64'(p_bi2);
    if (op2 == OP_MUL) begin
      simple2m     = '0;
      simple2m.re  = m_re.val;
      simple2m.im  = m_im.val;
      simple2m.ovf = m_re.ovf | m_im.ovf;
    end else begin
      simple2m = simple2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3     <= op2;
      simple3 <= simple2m;
      ar3     <= ar2;
      ai3     <= ai2;
      num_re3 <= 66'(p_rr) + 66'(p_ii);
      num_im3 <= 66'(p_ir) - 66'(p_ri);
      den3    <= den_c;
      dz3     <= den_c == '0;
      sumsq3  <= 64'(p_ar2) + 64'(p_ai2);
    end
  end

  cau_div u_div_re (
    .clk (clk),
    .en  (en),
    .num (num_re3),
    .den (den3),
    .quo (dq_re),
    .ovf (dovf_re)
  );

  cau_div u_div_im (
    .clk (clk),
    .en  (en),
    .num (num_im3),
    .den (den3),
    .quo (dq_im),
    .ovf (dovf_im)
  );

  cau_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .sq  (sumsq3),
    .mag (sq_mag),
    .ovf (sq_ovf)
  );

  cau_cordic u_cordic (
    .clk  (clk),
    .en   (en),
    .a_re (ar3),
    .a_im (ai3),
    .ang  (ang)
  );

  // control and simple results ride alongside the units
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < UNIT_LAT; k++) begin
        tl_v[k] <= 1'b0;
      end
    end else if (en) begin
      tl_v[0] <= v3;
      for (int k = 1; k < UNIT_LAT; k++) begin
        tl_v[k] <= tl_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tl_op[0]  <= op3;
      tl_res[0] <= simple3;
      tl_dz[0]  <= dz3;
      for (int k = 1; k < UNIT_LAT; k++) begin
        tl_op[k]  <= tl_op[k-1];
        tl_res[k] <= tl_res[k-1];
        tl_dz[k]  <= tl_dz[k-1];
      end
    end
  end

  always_comb begin
    fin = '0;
    unique case (tl_op[UNIT_LAT-1])
      OP_DIV: begin
        if (tl_dz[UNIT_LAT-1]) begin
          fin.dz = 1'b1;
        end else begin
          fin.re  = dq_re;
          fin.im  = dq_im;
          fin.ovf = dovf_re | dovf_im;
        end
      end
      OP_MAG: begin
        fin.re  = sq_mag;
        fin.ovf = sq_ovf;
      end
      OP_ANG: begin
        fin.re = ang;
      end
      default: begin
        fin = tl_res[UNIT_LAT-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tl_v[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= fin;
    end
  end

  assign res_re   = out_res.re;
  assign res_im   = out_res.im;
  assign equal    = out_res.eq;
  assign div_zero = out_res.dz;
  assign overflow = out_res.ovf;
endmodule

// ----- sv/cau_checker.sv -----
// port-level checks of the complex arithmetic unit, bound to the top level
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_assert.svh"
module cau_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] res_re,
  input logic signed [31:0] res_im,
  input logic               equal,
  input logic               div_zero,
  input logic               overflow
);
  // a held output beat keeps its data
  `CAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_re) && $stable(res_im))
  // zero denominator gives clean zeros
  `CAU_ASSERT_NOW(a_dz_zero, out_valid && div_zero, res_re == 0 && res_im == 0 && !overflow && !equal)
  // compare beats carry only the flag
  `CAU_ASSERT_NOW(a_eq_alone, out_valid && equal, res_re == 0 && res_im == 0 && !div_zero && !overflow)
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// ----- tb/tb_complex_arithmetic_unit.sv -----
// testbench for the complex arithmetic unit: random and directed beats checked against a predictor
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int  N_RANDOM    = 1600;
  localparam int  DRAIN_WAIT  = 80;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  FRAC        = 16;
  localparam longint ATAN_Q16 [17] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                       58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                       229, 115, 57};

  class cau_scoreboard;
    res_t   awaited_q[$];
    int     errors;

    function void note(res_t e);
      awaited_q.push_back(e);
    endfunction

    function void check(res_t a);
      res_t e;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat re=%0d im=%0d", a.re, a.im);
      end else begin
        e = awaited_q.pop_front();
        if (e !== a) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp re=%0d im=%0d eq=%b dz=%b ovf=%b, ",
                      "got re=%0d im=%0d eq=%b dz=%b ovf=%b"},
                     e.re, e.im, e.eq, e.dz, e.ovf, a.re, a.im, a.eq, a.dz, a.ovf);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         cmd = CMD_ADD;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] res_re, res_im;
  logic               equal, div_zero, overflow;

  cau_scoreboard results_sb = new();
  int                 cycle_cnt = 0;
  bit                 drained = 1'b0;

  complex_arithmetic_unit u_top (
    .clk, .rst, .in_valid, .in_ready, .cmd, .a_re, .a_im, .b_re, .b_im,
    .out_valid, .out_ready, .res_re, .res_im, .equal, .div_zero, .overflow
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] clip(input logic signed [127:0] v, inout logic o);
    if (v > 128'sh7FFF_FFFF) begin
      o = 1'b1;
      return MAX32;
    end else if (v < -128'sh8000_0000) begin
      o = 1'b1;
      return MIN32;
    end
    return v[31:0];
  endfunction

  // floor(num * 2^FRAC / den)
  function automatic logic signed [127:0] floor_quot(input logic signed [127:0] num,
                                                     input logic [127:0] den);
    logic [127:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC) / den;
    if (num < 0) begin
      if ((mag << FRAC) % den != 0) q = q + 1;
      return -$signed(q);
    end
    return $signed(q);
  endfunction

  function automatic longint angle_deg(input logic signed [31:0] re,
                                       input logic signed [31:0] im);
    longint mx, my, mm, x, y, z, dx, dy;
    int p;
    if (im == 0) return (re < 0) ? longint'(DEG180) : 0;
    if (re == 0) return (im < 0) ? -longint'(DEG90) : longint'(DEG90);
    mx = (re < 0) ? -longint'(re) : longint'(re);
    my = (im < 0) ? -longint'(im) : longint'(im);
    mm = (mx > my) ? mx : my;
    p = 0;
    while (p < 63 && (mm >> (p + 1)) != 0) p++;
    if (p > 30) begin
      mx = mx >> (p - 30);
      my = my >> (p - 30);
    end else begin
      mx = mx << (30 - p);
      my = my << (30 - p);
    end
    x = mx;
    y = ((re < 0) != (im < 0)) ? -my : my;
    z = 0;
    for (int i = 0; i < 17; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q16[i];
      end
    end
    if (re < 0) z += (im < 0) ? -longint'(DEG180) : longint'(DEG180);
    return z;
  endfunction

  function automatic res_t predict_result(input logic [2:0] c, input logic signed [31:0] ar,
                                          input logic signed [31:0] ai,
                                          input logic signed [31:0] br,
                                          input logic signed [31:0] bi);
    logic signed [127:0] xr, xi, yr, yi;
    logic [127:0] den, s, r, t;
    res_t e;
    logic o;
    e = '0;
    o = 1'b0;
    xr = 128'(ar); xi = 128'(ai); yr = 128'(br); yi = 128'(bi);
    case (c)
      CMD_ADD: begin
        e.re = clip(xr + yr, o); e.im = clip(xi + yi, o);
      end
      CMD_SUB: begin
        e.re = clip(xr - yr, o); e.im = clip(xi - yi, o);
      end
      CMD_MUL: begin
        e.re = clip((xr * yr - xi * yi) >>> FRAC, o);
        e.im = clip((xr * yi + xi * yr) >>> FRAC, o);
      end
      CMD_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) e.dz = 1'b1;
        else begin
          e.re = clip(floor_quot(xr * yr + xi * yi, den), o);
          e.im = clip(floor_quot(xi * yr - xr * yi, den), o);
        end
      end
      CMD_CMP: e.eq = (ar == br) && (ai == bi);
      CMD_MAG: begin
        s = xr * xr + xi * xi;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
          t = r | (128'd1 << b);
          if (t * t <= s) r = t;
        end
        e.re = clip($signed(r), o);
      end
      CMD_ANG: e.re = clip(128'(angle_deg(ar, ai)), o);
      default: ;
    endcase
    e.ovf = o;
    return e;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_beat(input logic [2:0] c, input logic signed [31:0] ar,
                           input logic signed [31:0] ai, input logic signed [31:0] br,
                           input logic signed [31:0] bi);
    int gap;
    in_valid <= 1'b1;
    cmd <= c; a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    do @(posedge clk); while (!in_ready);
    results_sb.note(predict_result(c, ar, ai, br, bi));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(7))
      0, 1:    return $urandom();
      2:       return $signed($urandom_range(8 << FRAC)) - (4 << FRAC);
      3:       return $signed($urandom_range(2000)) - 1000;
      4:       return '0;
      5:       return ($urandom_range(1)) ? MAX32 : MIN32;
      6:       return $signed($urandom_range(65535)) <<< $urandom_range(16);
      default: return (1 << FRAC) * ($signed($urandom_range(6)) - 3);
    endcase
  endfunction

  task automatic random_beat();
    logic [2:0] c;
    logic signed [31:0] ar, ai, br, bi;
    c = 3'($urandom_range(7));
    ar = pick_operand(); ai = pick_operand();
    br = pick_operand(); bi = pick_operand();
    case ($urandom_range(9))
      0: begin br = '0; bi = '0; end
      1: begin br = ar; bi = ai; end
      2: ai = '0;
      3: ar = '0;
      default: ;
    endcase
    send_beat(c, ar, ai, br, bi);
  endtask

  // receiver: one long hold-off early on, then random stalls
  initial begin
    int n;
    repeat (6) @(posedge clk);
    out_ready <= 1'b1;
    repeat (120) @(posedge clk);
    out_ready <= 1'b0;
    repeat (300) @(posedge clk);
    forever begin
      n = $urandom_range(99);
      if (n < 40) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 1)) @(posedge clk);
      end else if (n < 93) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(50, 10)) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && out_valid && out_ready) begin
      got.re = res_re; got.im = res_im; got.eq = equal; got.dz = div_zero; got.ovf = overflow;
      results_sb.check(got);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT && !drained) begin
      $display("[complex_arithmetic_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes, overflow, zero denominator, compare, magnitude, axes of the angle, an undefined command
    send_beat(CMD_ADD, MAX32, MIN32, MAX32, MIN32);
    send_beat(CMD_ADD, 32'sd1, -32'sd1, 32'sd2, 32'sd5);
    send_beat(CMD_SUB, MIN32, MAX32, MAX32, MIN32);
    send_beat(CMD_SUB, MAX32, MAX32, MAX32, MAX32);
    send_beat(CMD_MUL, MIN32, MIN32, MIN32, MIN32);
    send_beat(CMD_MUL, -32'sd1, 32'sd3, 32'sd1, 32'sd1);
    send_beat(CMD_MUL, 32'sh0002_8000, -32'sh0001_0000, 32'sh0000_C000, 32'sh0003_0000);
    send_beat(CMD_DIV, 32'sh0001_0000, 32'sh0002_0000, '0, '0);
    send_beat(CMD_DIV, '0, '0, 32'sh0001_0000, 32'sh0001_0000);
    send_beat(CMD_DIV, MIN32, MAX32, 32'sd1, '0);
    send_beat(CMD_DIV, -32'sh0003_0000, 32'sh0001_0000, 32'sh0000_7000, -32'sh0002_0000);
    send_beat(CMD_CMP, MIN32, MAX32, MIN32, MAX32);
    send_beat(CMD_CMP, MIN32, MAX32, MIN32, MIN32);
    send_beat(CMD_MAG, MIN32, MIN32, '0, '0);
    send_beat(CMD_MAG, '0, '0, '0, '0);
    send_beat(CMD_MAG, 32'sh0003_0000, -32'sh0004_0000, '0, '0);
    send_beat(CMD_ANG, '0, '0, '0, '0);
    send_beat(CMD_ANG, 32'sh0001_0000, '0, '0, '0);
    send_beat(CMD_ANG, -32'sh0001_0000, '0, '0, '0);
    send_beat(CMD_ANG, '0, 32'sh0001_0000, '0, '0);
    send_beat(CMD_ANG, '0, MIN32, '0, '0);
    send_beat(CMD_ANG, -32'sh0001_0000, -32'sh0001_0000, '0, '0);
    send_beat(CMD_ANG, MIN32, 32'sd1, '0, '0);
    send_beat(3'd7, MAX32, MIN32, MAX32, MIN32);
    repeat (N_RANDOM) random_beat();
    in_valid <= 1'b0;
    while (results_sb.awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    drained = 1'b1;
    if (results_sb.errors == 0) $display("[complex_arithmetic_unit] OK");
    else $display("[complex_arithmetic_unit] ERROR");
    $finish;
  end
endmodule

// ----- complex_arithmetic_unit.f -----
+incdir+sv
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_div.sv
sv/cau_sqrt.sv
sv/cau_cordic.sv
sv/complex_arithmetic_unit.sv
sv/cau_checker.sv
tb/tb_complex_arithmetic_unit.sv
